// ===== rtl/idxh_pkg.sv =====
// ----------------------------------------------------------------------------
// idxh_pkg
// shared request and status codes of the indexed max-heap core
// ----------------------------------------------------------------------------
package idxh_pkg;

  localparam int unsigned VID_W = 10;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_BAD_POS = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_DUP     = 3'd4;

endpackage

// ===== rtl/idxh_ram.sv =====
// ----------------------------------------------------------------------------
// idxh_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module idxh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/indexed_max_heap_core.sv =====
// ----------------------------------------------------------------------------
// indexed_max_heap_core
// indexed binary max-heap with vertex position map
// ----------------------------------------------------------------------------
// Requests are handled one at a time. After reset the position map is cleared
// one entry a cycle with in_stall_o high. An insert or delete walks the tree
// one level at a time through the heap ram's single read port (read, compare,
// write back), climbing through S_UPGO and S_UPCK and descending through
// S_DNGO, S_DNL and S_DNR; a query reads the position map and then the top
// entry. One result beat per request, unknown request codes return ok with
// no change.
module indexed_max_heap_core
  import idxh_pkg::*;
#(
  parameter int unsigned CAPACITY     = 1024,
  parameter int unsigned VERTEX_COUNT = 1024,
  parameter int unsigned KEY_BITS     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [9:0]  vertex_id_i,
  input  logic [31:0] node_key_i,
  input  logic [9:0]  heap_position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [9:0]  found_position_o,
  output logic [9:0]  top_vertex_o,
  output logic [31:0] top_key_o,
  output logic        heap_empty_o,
  output logic [10:0] entry_count_o
);

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = $clog2(VERTEX_COUNT);
  localparam int unsigned HW = VID_W + KEY_BITS;

  typedef enum logic [11:0] {
    S_CLR     = 12'b000000000001,
    S_IDLE    = 12'b000000000010,
    S_PMCHK   = 12'b000000000100,
    S_DELRD   = 12'b000000001000,
    S_DELLAST = 12'b000000010000,
    S_UPGO    = 12'b000000100000,
    S_UPCK    = 12'b000001000000,
    S_DNGO    = 12'b000010000000,
    S_DNL     = 12'b000100000000,
    S_DNR     = 12'b001000000000,
    S_TOPRD   = 12'b010000000000,
    S_TOP     = 12'b100000000000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [SW-1:0]        at_q, at_d;
  logic [VID_W-1:0]     ev_q, ev_d, lv_q, lv_d;
  logic [KEY_BITS-1:0]  ek_q, ek_d, lk_q, lk_d;
  logic [1:0]           op_q, op_d;
  logic [2:0]           st_q, st_d;
  logic [9:0]           fnd_q, fnd_d;
  logic [PW:0]          clr_q, clr_d;

  logic                 h_we;
  logic [SW-1:0]        h_waddr, h_raddr;
  logic [HW-1:0]        h_wdata, h_rdata;
  logic                 p_we;
  logic [PW-1:0]        p_waddr, p_raddr;
  logic [SW:0]          p_wdata, p_rdata;

  logic                 accept;
  logic                 out_take;
  logic [31:0]          lw, rw, cnt_w;
  logic [SW-1:0]        lidx, ridx, pidx;
  logic [VID_W-1:0]     rv;
  logic [KEY_BITS-1:0]  rk;
  logic                 vid_bad;

  idxh_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  idxh_ram #(.WIDTH(SW + 1), .DEPTH(VERTEX_COUNT)) u_pmap_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  assign out_take   = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_o && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign cnt_w   = 32'(cnt_q);
  assign lw      = 32'({at_q, 1'b1});
  assign rw      = lw + 32'd1;
  assign lidx    = SW'(lw);
  assign ridx    = SW'(rw);
  assign pidx    = SW'((at_q - SW'(1)) >> 1);
  assign rv      = h_rdata[HW-1:KEY_BITS];
  assign rk      = h_rdata[KEY_BITS-1:0];
  assign vid_bad = 32'(vertex_id_i) >= 32'(VERTEX_COUNT);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    at_d    = at_q;
    ev_d    = ev_q;
    ek_d    = ek_q;
    lv_d    = lv_q;
    lk_d    = lk_q;
    op_d    = op_q;
    st_d    = st_q;
    fnd_d   = fnd_q;
    clr_d   = clr_q;
    h_we    = 1'b0;
    h_waddr = at_q;
    h_wdata = {ev_q, ek_q};
    h_raddr = '0;
    p_we    = 1'b0;
    p_waddr = PW'(ev_q);
    p_wdata = {1'b1, at_q};
    p_raddr = PW'(vertex_id_i);
    case (state_q)
      S_CLR: begin
        p_we    = 1'b1;
        p_waddr = PW'(clr_q);
        p_wdata = '0;
        clr_d   = clr_q + (PW+1)'(1);
        if (clr_q == (PW+1)'(VERTEX_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d  = req_type_i;
          st_d  = ST_OK;
          fnd_d = '0;
          ev_d  = vertex_id_i;
          ek_d  = KEY_BITS'(node_key_i);
          at_d  = SW'(heap_position_i);
          h_raddr = SW'(heap_position_i);
          case (req_type_i)
            REQ_INSERT, REQ_QUERY: begin
              if (vid_bad) begin
                st_d    = ST_ABSENT;
                state_d = S_TOPRD;
              end else begin
                state_d = S_PMCHK;
              end
            end
            REQ_DELETE: begin
              if (32'(heap_position_i) >= cnt_w) begin
                st_d    = ST_BAD_POS;
                state_d = S_TOPRD;
              end else begin
                state_d = S_DELRD;
              end
            end
            default: state_d = S_TOPRD;
          endcase
        end
      end
      S_PMCHK: begin
        if (op_q == REQ_QUERY) begin
          if (p_rdata[SW]) begin
            fnd_d = 10'(p_rdata[SW-1:0]);
          end else begin
            st_d = ST_ABSENT;
          end
          state_d = S_TOPRD;
        end else if (p_rdata[SW]) begin
          st_d    = ST_DUP;
          state_d = S_TOPRD;
        end else if (cnt_w >= 32'(CAPACITY)) begin
          st_d    = ST_FULL;
          state_d = S_TOPRD;
        end else begin
          at_d    = SW'(cnt_q);
          cnt_d   = cnt_q + CW'(1);
          state_d = S_UPGO;
        end
      end
      S_DELRD: begin
        p_we    = 1'b1;
        p_waddr = PW'(rv);
        p_wdata = '0;
        h_raddr = SW'(cnt_q - CW'(1));
        if (32'(at_q) == cnt_w - 32'd1) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_TOPRD;
        end else begin
          state_d = S_DELLAST;
        end
      end
      S_DELLAST: begin
        ev_d    = rv;
        ek_d    = rk;
        cnt_d   = cnt_q - CW'(1);
        state_d = S_UPGO;
      end
      S_UPGO: begin
        h_raddr = pidx;
        if (at_q == '0) begin
          state_d = S_DNGO;
        end else begin
          state_d = S_UPCK;
        end
      end
      S_UPCK: begin
        if (ek_q > rk) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          p_we    = 1'b1;
          p_waddr = PW'(rv);
          at_d    = pidx;
          state_d = S_UPGO;
        end else begin
          state_d = S_DNGO;
        end
      end
      S_DNGO: begin
        h_raddr = lidx;
        if (lw >= cnt_w) begin
          h_we    = 1'b1;
          p_we    = 1'b1;
          state_d = S_TOPRD;
        end else begin
          state_d = S_DNL;
        end
      end
      S_DNL: begin
        lv_d    = rv;
        lk_d    = rk;
        h_raddr = ridx;
        if (rw < cnt_w) begin
          state_d = S_DNR;
        end else if (rk > ek_q) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          p_we    = 1'b1;
          p_waddr = PW'(rv);
          at_d    = lidx;
          state_d = S_DNGO;
        end else begin
          h_we    = 1'b1;
          p_we    = 1'b1;
          state_d = S_TOPRD;
        end
      end
      S_DNR: begin
        if (rk > ((lk_q > ek_q) ? lk_q : ek_q)) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          p_we    = 1'b1;
          p_waddr = PW'(rv);
          at_d    = ridx;
          state_d = S_DNGO;
        end else if (lk_q > ek_q) begin
          h_we    = 1'b1;
          h_wdata = {lv_q, lk_q};
          p_we    = 1'b1;
          p_waddr = PW'(lv_q);
          at_d    = lidx;
          state_d = S_DNGO;
        end else begin
          h_we    = 1'b1;
          p_we    = 1'b1;
          state_d = S_TOPRD;
        end
      end
      S_TOPRD: begin
        h_raddr = '0;
        state_d = S_TOP;
      end
      S_TOP: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    at_q  <= at_d;
    ev_q  <= ev_d;
    ek_q  <= ek_d;
    lv_q  <= lv_d;
    lk_q  <= lk_d;
    op_q  <= op_d;
    st_q  <= st_d;
    fnd_q <= fnd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == S_TOP) begin
      out_valid_o <= 1'b1;
    end else if (out_take) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_TOP) begin
      status_o         <= st_q;
      found_position_o <= fnd_q;
      entry_count_o    <= 11'(cnt_q);
      heap_empty_o     <= (cnt_q == '0);
      if (cnt_q == '0) begin
        top_vertex_o <= '0;
        top_key_o    <= '0;
      end else begin
        top_vertex_o <= rv;
        top_key_o    <= 32'(rk);
      end
    end
  end

endmodule

// ===== rtl/idxh_checker.sv =====
// ----------------------------------------------------------------------------
// idxh_checker
// port-level checks of the indexed max-heap core, bound into the core module
// ----------------------------------------------------------------------------
module idxh_checker
  import idxh_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [9:0]  found_position_o,
  input logic [9:0]  top_vertex_o,
  input logic [31:0] top_key_o,
  input logic        heap_empty_o,
  input logic [10:0] entry_count_o
);

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result beat right after request beat");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heap_empty_o == (entry_count_o == 11'd0)))
    else $error("empty flag disagrees with count");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && heap_empty_o) |-> (top_key_o == 32'd0 && top_vertex_o == 10'd0))
    else $error("top entry nonzero on empty heap");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (found_position_o == 10'd0))
    else $error("position reported on failed request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(top_key_o)))
    else $error("stalled result beat changed");

endmodule

bind indexed_max_heap_core idxh_checker u_idxh_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for indexed_max_heap_core: random insert, delete and
// query beats go in, each result beat is checked against a heap model kept
// in the bench, with idle and stall phases and a long output hold-off
// ----------------------------------------------------------------------------
module tb;
  import idxh_pkg::*;

  localparam int unsigned CAP = 1024;
  localparam int unsigned NVTX = 1024;

  typedef struct packed {
    logic [1:0]  req;
    logic [9:0]  vid;
    logic [31:0] key;
    logic [9:0]  pos;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  found;
    logic [9:0]  top_vid;
    logic [31:0] top_key;
    logic        empty;
    logic [10:0] count;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [9:0]  vertex_id_i = '0;
  logic [31:0] node_key_i = '0;
  logic [9:0]  heap_position_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [9:0]  found_position_o;
  logic [9:0]  top_vertex_o;
  logic [31:0] top_key_o;
  logic        heap_empty_o;
  logic [10:0] entry_count_o;

  indexed_max_heap_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // heap model
  logic [9:0]  h_vid [CAP];
  logic [31:0] h_key [CAP];
  int unsigned slot_of [NVTX];
  bit          present [NVTX];
  int unsigned fill;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   errors;
  int   send_idle_pct, recv_stall_pct;
  bit   hold_off, stim_done;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [9:0]  tv;
    logic [31:0] tk;
    tv = h_vid[a]; tk = h_key[a];
    h_vid[a] = h_vid[b]; h_key[a] = h_key[b];
    h_vid[b] = tv; h_key[b] = tk;
    slot_of[h_vid[a]] = a;
    slot_of[h_vid[b]] = b;
  endfunction

  function automatic void bubble_up(int unsigned at);
    int unsigned up;
    while (at > 0) begin
      up = (at - 1) / 2;
      if (!(h_key[at] > h_key[up])) break;
      swap_slots(at, up);
      at = up;
    end
  endfunction

  function automatic void bubble_down(int unsigned at);
    int unsigned best, l, r;
    forever begin
      best = at; l = 2 * at + 1; r = 2 * at + 2;
      if (l < fill && h_key[l] > h_key[best]) best = l;
      if (r < fill && h_key[r] > h_key[best]) best = r;
      if (best == at) break;
      swap_slots(at, best);
      at = best;
    end
  endfunction

  function automatic res_t heap_apply(req_t r);
    res_t o;
    int unsigned last;
    o = '0;
    o.status = ST_OK;
    if (r.req == REQ_INSERT) begin
      if (present[r.vid]) o.status = ST_DUP;
      else if (fill >= CAP) o.status = ST_FULL;
      else begin
        h_vid[fill] = r.vid; h_key[fill] = r.key;
        slot_of[r.vid] = fill; present[r.vid] = 1'b1;
        fill++;
        bubble_up(fill - 1);
      end
    end else if (r.req == REQ_DELETE) begin
      if (r.pos >= fill) o.status = ST_BAD_POS;
      else begin
        last = fill - 1;
        present[h_vid[r.pos]] = 1'b0;
        if (r.pos != last) begin
          h_vid[r.pos] = h_vid[last]; h_key[r.pos] = h_key[last];
          slot_of[h_vid[r.pos]] = r.pos;
        end
        fill = last;
        if (r.pos < fill) begin
          bubble_up(r.pos);
          bubble_down(r.pos);
        end
      end
    end else if (r.req == REQ_QUERY) begin
      if (!present[r.vid]) o.status = ST_ABSENT;
      else o.found = 10'(slot_of[r.vid]);
    end
    if (fill > 0) begin
      o.top_vid = h_vid[0]; o.top_key = h_key[0]; o.empty = 1'b0;
    end else o.empty = 1'b1;
    o.count = 11'(fill);
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("error: %s got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void queue_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && in_stall_o)) begin
      if (in_valid_i)
        expected_results.insert(expected_results.size(),
                                heap_apply(pending_reqs.pop_front()));
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        req_type_i <= pending_reqs[0].req;
        vertex_id_i <= pending_reqs[0].vid;
        node_key_i <= pending_reqs[0].key;
        heap_position_i <= pending_reqs[0].pos;
      end else in_valid_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) report("unexpected beat", 0, 0);
        else begin
          w = expected_results.pop_front();
          if (status_o !== w.status) report("status", status_o, w.status);
          if (found_position_o !== w.found) report("found_position", found_position_o, w.found);
          if (top_vertex_o !== w.top_vid) report("top_vertex", top_vertex_o, w.top_vid);
          if (top_key_o !== w.top_key) report("top_key", top_key_o, w.top_key);
          if (heap_empty_o !== w.empty) report("heap_empty", heap_empty_o, w.empty);
          if (entry_count_o !== w.count) report("entry_count", entry_count_o, w.count);
        end
      end
      out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic req_t mk(logic [1:0] q, logic [9:0] v, logic [31:0] k, logic [9:0] p);
    req_t r;
    r.req = q; r.vid = v; r.key = k; r.pos = p;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  // random beat biased toward a busy heap; size tracked by count of live vertices
  function automatic req_t rand_req(int unsigned live);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return mk(REQ_INSERT, 10'($urandom_range(NVTX - 1)),
                            ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom, 0);
    if (sel < 80) return mk(REQ_DELETE, 10'($urandom), $urandom,
                            10'(($urandom_range(9) == 0) ? $urandom : $urandom_range(live + 2)));
    if (sel < 97) return mk(REQ_QUERY, 10'($urandom_range(NVTX - 1)), $urandom, 10'($urandom));
    return mk(2'd3, 10'($urandom), $urandom, 10'($urandom));
  endfunction

  initial begin
    fill = 0;
    foreach (present[i]) present[i] = 1'b0;
    errors = 0; send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0; stim_done = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    queue_req(mk(REQ_DELETE, 0, 0, 0));
    queue_req(mk(REQ_QUERY, 0, 0, 0));
    queue_req(mk(REQ_INSERT, 0, 32'h0, 0));
    queue_req(mk(REQ_INSERT, 10'h3ff, 32'hffff_ffff, 0));
    queue_req(mk(REQ_INSERT, 5, 32'h10, 0));
    queue_req(mk(REQ_INSERT, 6, 32'h10, 0));
    queue_req(mk(REQ_INSERT, 5, 32'h20, 0));
    queue_req(mk(REQ_QUERY, 10'h3ff, 0, 0));
    queue_req(mk(REQ_QUERY, 6, 0, 0));
    queue_req(mk(REQ_QUERY, 7, 0, 0));
    queue_req(mk(2'd3, 10'h3ff, 32'hffff_ffff, 10'h3ff));
    queue_req(mk(REQ_DELETE, 0, 0, 10'h3ff));
    queue_req(mk(REQ_DELETE, 0, 0, 4));
    queue_req(mk(REQ_DELETE, 0, 0, 3));
    queue_req(mk(REQ_DELETE, 0, 0, 0));
    queue_req(mk(REQ_QUERY, 10'h3ff, 0, 0));
    queue_req(mk(REQ_DELETE, 0, 0, 0));
    queue_req(mk(REQ_DELETE, 0, 0, 0));
    queue_req(mk(REQ_DELETE, 0, 0, 0));
    wait_drained();
    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 74 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 74 : 0;
      if (ph == 3) begin send_idle_pct = 8; recv_stall_pct = 8; end
      for (int i = 0; i < 100; i++) queue_req(rand_req(fill + 4));
      if (ph == 0) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      wait_drained();
    end
    // fill to capacity, duplicate inserts on the full heap, then 60 deletes
    send_idle_pct = 0; recv_stall_pct = 8;
    for (int v = 0; v < NVTX; v++) queue_req(mk(REQ_INSERT, 10'(v), $urandom, 0));
    queue_req(mk(REQ_INSERT, 3, 1, 0));
    wait_drained();
    for (int v = 0; v < 3; v++) queue_req(mk(REQ_INSERT, 0, 1, 0));
    for (int i = 0; i < 60; i++)
      queue_req(mk(REQ_DELETE, 0, 0, (i % 3 == 0) ? 10'd0 : 10'($urandom_range(1023))));
    wait_drained();
    repeat (80) @(posedge clk_i);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
